[rtl/pwt_pkg.sv]
// Package for the protobuf wire tokenizer.
// Holds event and error codes and the result record shared by core and top level.
// No dependencies.
package pwt_pkg;

    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 32;
    localparam int WIRE_W  = 3;
    localparam int VALUE_W = 64;
    localparam int EVENT_W = 3;
    localparam int ERROR_W = 3;

    localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EVENT_W-1:0] EV_TAG     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_VARINT  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_LENGTH  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_PAYLOAD = 3'd4;

    localparam logic [ERROR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERROR_W-1:0] ERR_ZERO_FIELD = 3'd1;
    localparam logic [ERROR_W-1:0] ERR_BAD_WIRE   = 3'd2;
    localparam logic [ERROR_W-1:0] ERR_TOO_LONG   = 3'd3;
    localparam logic [ERROR_W-1:0] ERR_TRUNCATED  = 3'd4;

    localparam logic [WIRE_W-1:0] WIRE_VARINT  = 3'd0;
    localparam logic [WIRE_W-1:0] WIRE_FIXED64 = 3'd1;
    localparam logic [WIRE_W-1:0] WIRE_LEN     = 3'd2;
    localparam logic [WIRE_W-1:0] WIRE_FIXED32 = 3'd5;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [FIELD_W-1:0] field_number;
        logic [WIRE_W-1:0]  wire_type;
        logic [VALUE_W-1:0] value;
        logic [BYTE_W-1:0]  data_byte;
        logic               data_last;
        logic               message_done;
        logic [ERROR_W-1:0] error_code;
    } res_t;

endpackage

[rtl/pwt_core.sv]
// Decode core of the protobuf wire tokenizer: tokenizer state registers and
// the single-pass next-state and result logic for one byte.
// Depends on pwt_pkg.
module pwt_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [pwt_pkg::BYTE_W-1:0] in_byte,
    input  logic                       end_of_message,
    output pwt_pkg::res_t              res
);
    import pwt_pkg::*;

    localparam logic [1:0] PH_TAG     = 2'd0;
    localparam logic [1:0] PH_VALUE   = 2'd1;
    localparam logic [1:0] PH_LEN     = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [3:0] CNT_LAST = 4'd9;

    logic [1:0]         phase_reg, phase_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [FIELD_W-1:0] field_reg, field_next;
    logic [WIRE_W-1:0]  wire_reg, wire_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [ERROR_W-1:0] err_reg, err_next;

    logic [5:0]         shift;
    logic [VALUE_W-1:0] acc_or;
    logic [VALUE_W-1:0] rem_dec;
    logic [EVENT_W-1:0] ev;
    logic [VALUE_W-1:0] vout;
    logic [BYTE_W-1:0]  dbyte;
    logic               dlast;

    assign shift   = 6'({2'b00, cnt_reg} * 6'd7);
    assign acc_or  = acc_reg | ({{(VALUE_W-7){1'b0}}, in_byte[6:0]} << shift);
    assign rem_dec = (rem_reg != '0) ? rem_reg - VALUE_W'(1) : '0;

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        field_next = field_reg;
        wire_next  = wire_reg;
        rem_next   = rem_reg;
        err_next   = err_reg;
        ev         = EV_NONE;
        vout       = '0;
        dbyte      = '0;
        dlast      = 1'b0;

        if (err_reg == ERR_NONE)
        begin
            if (phase_reg == PH_PAYLOAD)
            begin
                ev       = EV_PAYLOAD;
                dbyte    = in_byte;
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    dlast      = 1'b1;
                    phase_next = PH_TAG;
                end
            end
            else
            begin
                acc_next = acc_or;
                if (!in_byte[7])
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    case (phase_reg)
                        PH_TAG:
                        begin
                            field_next = acc_or[FIELD_W+2:3];
                            wire_next  = acc_or[WIRE_W-1:0];
                            if (acc_or[FIELD_W+2:3] == '0)
                            begin
                                err_next = ERR_ZERO_FIELD;
                            end
                            else
                            begin
                                case (acc_or[WIRE_W-1:0])
                                    WIRE_VARINT:
                                    begin
                                        ev         = EV_TAG;
                                        phase_next = PH_VALUE;
                                    end
                                    WIRE_FIXED64:
                                    begin
                                        ev         = EV_TAG;
                                        phase_next = PH_PAYLOAD;
                                        rem_next   = VALUE_W'(8);
                                    end
                                    WIRE_LEN:
                                    begin
                                        ev         = EV_TAG;
                                        phase_next = PH_LEN;
                                    end
                                    WIRE_FIXED32:
                                    begin
                                        ev         = EV_TAG;
                                        phase_next = PH_PAYLOAD;
                                        rem_next   = VALUE_W'(4);
                                    end
                                    default:
                                    begin
                                        err_next = ERR_BAD_WIRE;
                                    end
                                endcase
                            end
                        end
                        PH_VALUE:
                        begin
                            ev         = EV_VARINT;
                            vout       = acc_or;
                            phase_next = PH_TAG;
                        end
                        default:
                        begin
                            ev   = EV_LENGTH;
                            vout = acc_or;
                            if (acc_or == '0)
                            begin
                                phase_next = PH_TAG;
                            end
                            else
                            begin
                                rem_next   = acc_or;
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    endcase
                end
                else if (cnt_reg >= CNT_LAST)
                begin
                    err_next = ERR_TOO_LONG;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
        end

        if (end_of_message && err_next == ERR_NONE &&
            (phase_next != PH_TAG || cnt_next != '0))
        begin
            err_next = ERR_TRUNCATED;
        end

        res.event_res    = ev;
        res.field_number = field_next;
        res.wire_type    = wire_next;
        res.value        = vout;
        res.data_byte    = dbyte;
        res.data_last    = dlast;
        res.message_done = end_of_message;
        res.error_code   = err_next;

        if (end_of_message)
        begin
            phase_next = PH_TAG;
            acc_next   = '0;
            cnt_next   = '0;
            field_next = '0;
            wire_next  = '0;
            rem_next   = '0;
            err_next   = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            field_reg <= '0;
            wire_reg  <= '0;
            rem_reg   <= '0;
            err_reg   <= ERR_NONE;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            field_reg <= field_next;
            wire_reg  <= wire_next;
            rem_reg   <= rem_next;
            err_reg   <= err_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("varint byte count out of range");

    a_payload_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD && err_reg == ERR_NONE) |-> rem_reg != '0)
        else $error("payload phase with no bytes remaining");

    a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && end_of_message) |=> (phase_reg == PH_TAG && err_reg == ERR_NONE
            && cnt_reg == '0 && acc_reg == '0))
        else $error("state not cleared after end of message");

    a_cnt_tag_only: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> cnt_reg == '0)
        else $error("varint bytes pending in payload phase");

endmodule

[rtl/protobuf_wire_tokenizer.sv]
// Protobuf wire tokenizer: one encoded byte per item in, one result item out.
// Each accepted byte lands in the input register, and its decode lands in the result
// register when the input register advances, which it does not while a result is held.
// Throughput: one item per cycle while results are taken every cycle; a held result
// holds a full input register, which then drops byte_ready until the result is taken.
// Reset (rst_n low, asynchronous): pipeline empty, tokenizer expects a tag, no error.
module protobuf_wire_tokenizer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_ready,
    input  logic [pwt_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        end_of_message,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [pwt_pkg::EVENT_W-1:0] event_res,
    output logic [pwt_pkg::FIELD_W-1:0] field_number,
    output logic [pwt_pkg::WIRE_W-1:0]  wire_type,
    output logic [pwt_pkg::VALUE_W-1:0] value,
    output logic [pwt_pkg::BYTE_W-1:0]  data_byte,
    output logic                        data_last,
    output logic                        message_done,
    output logic [pwt_pkg::ERROR_W-1:0] error_code
);
    import pwt_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eom_reg;
    logic              out_valid_reg;
    res_t              res_next;
    res_t              res_reg;
    logic              advance;

    assign advance    = in_valid_reg && (!out_valid_reg || result_ready);
    assign byte_ready = !in_valid_reg || advance;

    pwt_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .in_byte        (in_byte_reg),
        .end_of_message (in_eom_reg),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_ready)
            begin
                in_valid_reg <= byte_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            in_byte_reg <= in_byte;
            in_eom_reg  <= end_of_message;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign event_res    = res_reg.event_res;
    assign field_number = res_reg.field_number;
    assign wire_type    = res_reg.wire_type;
    assign value        = res_reg.value;
    assign data_byte    = res_reg.data_byte;
    assign data_last    = res_reg.data_last;
    assign message_done = res_reg.message_done;
    assign error_code   = res_reg.error_code;

endmodule
